// ----- rtl/core/pid_controller_step_core_assert.svh -----
// Assertion macros shared by the checker of the PID step core.
`ifndef PID_CONTROLLER_STEP_CORE_ASSERT_SVH
`define PID_CONTROLLER_STEP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pcs_pkg.sv -----
// Package: widths, constants and helper functions of the PID step core.
package pcs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FW        = FRAC_BITS + 1;   // fraction in [0, ONE]
    localparam int MA_W      = 48;              // multiplicand width
    localparam int MB_W      = 32;              // multiplier width
    localparam int MP_W      = MA_W + MB_W;     // product width
    localparam int CNT_W     = 5;               // counts MB_W steps

    localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

    // Configuration register indexes.
    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INT_RATE   = 3'd1;
    localparam logic [2:0] REG_DER_RATE   = 3'd2;
    localparam logic [2:0] REG_INPUT_MIN  = 3'd3;
    localparam logic [2:0] REG_SPAN_RECIP = 3'd4;
    localparam logic [2:0] REG_OUTPUT_MIN = 3'd5;
    localparam logic [2:0] REG_OUT_SPAN   = 3'd6;
    localparam logic [2:0] REG_INTERVAL   = 3'd7;

    // Signed 16-bit difference, one bit wider.
    function automatic logic signed [16:0] diff16s(logic [15:0] x, logic [15:0] m);
        logic signed [16:0] xs;
        logic signed [16:0] ms;
        xs = $signed({x[15], x});
        ms = $signed({m[15], m});
        return xs - ms;
    endfunction

    // Take (d * recip) >> 16 and clamp to ONE.
    function automatic logic [FW-1:0] in_clamp(logic [MP_W-1:0] p);
        logic [47:0] q;
        q = p[63:16];
        return (q > 48'(ONE)) ? ONE : q[FW-1:0];
    endfunction

endpackage

// ----- rtl/core/pid_controller_step_core.sv -----
// Top level of the PID step core: registers, sequencer and output stage.
//
//  channel   | handshake                   | word
//  ----------+-----------------------------+-------------------------------------
//  input     | s_axis_tvalid/s_axis_tready | measurement, setpoint, time, mode
//  output    | m_axis_tvalid/m_axis_tready | drive, computed flag, mode
//  config    | cfg_we (no wait)            | cfg_index selects, cfg_wdata value
//
// One word at a time. A word that computes nothing passes only through the mode,
// due and output states; one that computes runs six products on the shared
// shift-add multiplier, plus a bit-serial division for a feed-forward bias;
// entering auto adds a division and one product.
// Reset clears all loop state and loads the register defaults; no sweep.
// A stalled output word holds in the output register; the next input word
// is taken meanwhile and waits at the end of its work for the register.
module pid_controller_step_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] measurement, [31:16] setpoint, [63:32] now_ms, [64] auto_enable,
    // [65] ff_enable, [81:66] ff_bias, [97:82] held_output, [103:98] zero
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] control_output, [16] computed, [17] in_auto, [23:18] zero
    output logic [23:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int FW = pcs_pkg::FW;

    // Sequencer codes.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MODE = 4'd1;
    localparam logic [3:0] ST_DIV  = 4'd2;
    localparam logic [3:0] ST_PIN  = 4'd3;
    localparam logic [3:0] ST_DUE  = 4'd4;
    localparam logic [3:0] ST_PV   = 4'd5;
    localparam logic [3:0] ST_SP   = 4'd6;
    localparam logic [3:0] ST_ERR  = 4'd7;
    localparam logic [3:0] ST_T1   = 4'd8;
    localparam logic [3:0] ST_T2   = 4'd9;
    localparam logic [3:0] ST_U    = 4'd10;
    localparam logic [3:0] ST_DRV  = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    // Configuration registers.
    logic [23:0] kc_reg;
    logic [23:0] taur_reg;
    logic [23:0] taud_reg;
    logic [15:0] in_min_reg;
    logic [31:0] recip_reg;
    logic [15:0] out_min_reg;
    logic [15:0] out_span_reg;
    logic [15:0] interval_reg;

    // Captured input word.
    logic [15:0] meas_reg;
    logic [15:0] sp_reg;
    logic [31:0] now_reg;
    logic        want_reg;
    logic        ff_reg;
    logic [15:0] ffb_reg;
    logic [15:0] held_reg;

    // Loop state.
    logic signed [31:0] acc_reg;
    logic [FW-1:0]      prev_in_reg;
    logic [FW-1:0]      prev_out_reg;
    logic [FW-1:0]      bias_reg;
    logic [31:0]        due_reg;
    logic               active_reg;
    logic [15:0]        drive_reg;

    // Working registers.
    logic [3:0]         state_reg;
    logic               launched_reg;
    logic               div_ff_reg;
    logic [FW-1:0]      rem_reg;
    logic [15:0]        quo_reg;
    logic [3:0]         cnt_reg;
    logic [FW-1:0]      pv_reg;
    logic [FW-1:0]      spf_reg;
    logic signed [17:0] err_reg;
    logic signed [41:0] t1_reg;
    logic signed [41:0] t2_reg;
    logic [FW-1:0]      o_reg;
    logic               computed_reg;
    logic               m_valid_reg;
    logic [23:0]        m_data_reg;

    // Multiplier hookup.
    logic                         mul_start;
    logic [pcs_pkg::MA_W-1:0]     mul_a;
    logic [pcs_pkg::MB_W-1:0]     mul_b;
    logic                         mul_done;
    logic [pcs_pkg::MP_W-1:0]     mul_prod;

    // Combinational terms.
    logic [15:0]        in_x;
    logic signed [16:0] in_d;
    logic [15:0]        in_b;
    logic [FW-1:0]      in_res;
    logic [15:0]        div_src;
    logic signed [16:0] div_d;
    logic [15:0]        span_eff;
    logic [16:0]        rem_dbl;
    logic               qbit;
    logic [16:0]        rem_new;
    logic signed [17:0] err;
    logic signed [17:0] dmeas;
    logic               hold_int;
    logic signed [32:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic [31:0]        acc_mag;
    logic signed [42:0] inner;
    logic [42:0]        inner_mag;
    logic [39:0]        t1_mag;
    logic [40:0]        t2_mag;
    logic [48:0]        u_mag;
    logic signed [51:0] o_sum;
    logic [FW-1:0]      o_clamp;
    logic [17:0]        drv_sum;
    logic [15:0]        drv_sat;
    logic [31:0]        due_add;
    logic [31:0]        due_new;

    pcs_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Input scaling: clamp negative offsets to zero before the product.
    assign in_x   = (state_reg == ST_SP) ? sp_reg : meas_reg;
    assign in_d   = pcs_pkg::diff16s(in_x, in_min_reg);
    assign in_b   = in_d[16] ? 16'd0 : in_d[15:0];
    assign in_res = pcs_pkg::in_clamp(mul_prod);

    // Bias scaling by restoring division, one quotient bit per cycle.
    assign div_src  = (div_ff_reg || ff_reg) ? ffb_reg : held_reg;
    assign div_d    = $signed({1'b0, div_src}) - $signed({1'b0, out_min_reg});
    assign span_eff = (out_span_reg == 16'd0) ? 16'd1 : out_span_reg;
    assign rem_dbl  = {rem_reg[15:0], 1'b0};
    assign qbit     = rem_dbl >= {1'b0, span_eff};
    assign rem_new  = qbit ? (rem_dbl - {1'b0, span_eff}) : rem_dbl;

    // Error, measurement slope and integrator with anti-windup.
    assign err   = $signed({1'b0, spf_reg}) - $signed({1'b0, pv_reg});
    assign dmeas = $signed({1'b0, pv_reg}) - $signed({1'b0, prev_in_reg});
    assign hold_int = ((prev_out_reg == pcs_pkg::ONE) && !err[17] && (err != 18'sd0))
                   || ((prev_out_reg == '0) && err[17]);
    assign acc_sum  = $signed({acc_reg[31], acc_reg}) + $signed({{15{err[17]}}, err});
    assign acc_sat  = (acc_sum[32] != acc_sum[31])
                    ? (acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                    : acc_sum[31:0];

    assign acc_mag   = acc_reg[31] ? (~acc_reg + 32'd1) : acc_reg;

    // Magnitudes and signed partial terms (truncate toward zero).
    logic signed [17:0] dmeas_hold_reg;
    logic [17:0]        dmh_mag;
    assign dmh_mag = dmeas_hold_reg[17] ? (~dmeas_hold_reg + 18'd1) : dmeas_hold_reg;

    assign inner = $signed({t1_reg[41], t1_reg})
                 + $signed({{25{err_reg[17]}}, err_reg})
                 - $signed({t2_reg[41], t2_reg});
    assign inner_mag = inner[42] ? (~inner + 43'd1) : inner;

    assign t1_mag = mul_prod[55:16];
    assign t2_mag = mul_prod[56:16];
    assign u_mag  = mul_prod[64:16];

    // Output fraction: bias plus the scaled loop term, clamped to [0, ONE].
    assign o_sum = inner[42]
                 ? ($signed(52'(bias_reg)) - $signed({3'b000, u_mag}))
                 : ($signed(52'(bias_reg)) + $signed({3'b000, u_mag}));
    assign o_clamp = o_sum[51] ? '0
                   : ((o_sum > $signed(52'(pcs_pkg::ONE))) ? pcs_pkg::ONE : o_sum[FW-1:0]);

    // Drive in output units, saturated at full scale.
    assign drv_sum = {2'b00, out_min_reg} + {1'b0, mul_prod[32:16]};
    assign drv_sat = (drv_sum[17:16] != 2'b00) ? 16'hFFFF : drv_sum[15:0];

    // Next due time; catch up to now after a late word.
    assign due_add = due_reg + {16'd0, interval_reg};
    assign due_new = (due_add < now_reg) ? (now_reg + {16'd0, interval_reg}) : due_add;

    // Launch a product on the first cycle of each product step.
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mul_start = 1'b0;
        unique case (state_reg)
            ST_PIN, ST_PV, ST_SP:
            begin
                mul_start = !launched_reg;
                mul_a     = pcs_pkg::MA_W'(recip_reg);
                mul_b     = pcs_pkg::MB_W'(in_b);
            end
            ST_T1:
            begin
                mul_start = !launched_reg;
                mul_a     = pcs_pkg::MA_W'(acc_mag);
                mul_b     = pcs_pkg::MB_W'(taur_reg);
            end
            ST_T2:
            begin
                mul_start = !launched_reg;
                mul_a     = pcs_pkg::MA_W'(dmh_mag);
                mul_b     = pcs_pkg::MB_W'(taud_reg);
            end
            ST_U:
            begin
                mul_start = !launched_reg;
                mul_a     = pcs_pkg::MA_W'(inner_mag);
                mul_b     = pcs_pkg::MB_W'(kc_reg);
            end
            ST_DRV:
            begin
                mul_start = !launched_reg;
                mul_a     = pcs_pkg::MA_W'(o_reg);
                mul_b     = pcs_pkg::MB_W'(out_span_reg);
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg       <= 24'd131072;
            taur_reg     <= 24'd13107;
            taud_reg     <= 24'd65536;
            in_min_reg   <= 16'd0;
            recip_reg    <= 32'd4198404;
            out_min_reg  <= 16'd0;
            out_span_reg <= 16'd255;
            interval_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcs_pkg::REG_PROP_GAIN:  kc_reg       <= cfg_wdata[23:0];
                pcs_pkg::REG_INT_RATE:   taur_reg     <= cfg_wdata[23:0];
                pcs_pkg::REG_DER_RATE:   taud_reg     <= cfg_wdata[23:0];
                pcs_pkg::REG_INPUT_MIN:  in_min_reg   <= cfg_wdata[15:0];
                pcs_pkg::REG_SPAN_RECIP: recip_reg    <= cfg_wdata;
                pcs_pkg::REG_OUTPUT_MIN: out_min_reg  <= cfg_wdata[15:0];
                pcs_pkg::REG_OUT_SPAN:   out_span_reg <= cfg_wdata[15:0];
                pcs_pkg::REG_INTERVAL:   interval_reg <= cfg_wdata[15:0];
                default:                 kc_reg       <= kc_reg;
            endcase
        end
    end

    // Capture the input word on acceptance.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            meas_reg <= s_axis_tdata[15:0];
            sp_reg   <= s_axis_tdata[31:16];
            now_reg  <= s_axis_tdata[63:32];
            want_reg <= s_axis_tdata[64];
            ff_reg   <= s_axis_tdata[65];
            ffb_reg  <= s_axis_tdata[81:66];
            held_reg <= s_axis_tdata[97:82];
        end
    end

    // Sequencer and loop state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            launched_reg   <= 1'b0;
            div_ff_reg     <= 1'b0;
            cnt_reg        <= '0;
            acc_reg        <= '0;
            prev_in_reg    <= '0;
            prev_out_reg   <= '0;
            bias_reg       <= '0;
            due_reg        <= '0;
            active_reg     <= 1'b0;
            drive_reg      <= '0;
            computed_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            pv_reg         <= '0;
            spf_reg        <= '0;
            err_reg        <= '0;
            dmeas_hold_reg <= '0;
            t1_reg         <= '0;
            t2_reg         <= '0;
            o_reg          <= '0;
            m_data_reg     <= '0;
        end
        else
        begin
            // Drop the output word once taken.
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_MODE;
                    end
                end
                ST_MODE:
                begin
                    // Mode update comes before the computation.
                    active_reg <= want_reg;
                    if (want_reg && !active_reg)
                    begin
                        div_ff_reg   <= 1'b0;
                        launched_reg <= 1'b0;
                        state_reg    <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_DUE;
                    end
                end
                ST_DIV:
                begin
                    if (!launched_reg)
                    begin
                        if (div_d[16] || (div_d == 17'sd0) || (div_d[15:0] >= span_eff))
                        begin
                            // Below the span floor or at/above its top: no division.
                            bias_reg <= (div_d[16] || (div_d == 17'sd0)) ? '0 : pcs_pkg::ONE;
                            if (!div_ff_reg)
                            begin
                                prev_out_reg <= (div_d[16] || (div_d == 17'sd0))
                                              ? '0 : pcs_pkg::ONE;
                                state_reg    <= ST_PIN;
                            end
                            else
                            begin
                                state_reg <= ST_T1;
                            end
                        end
                        else
                        begin
                            rem_reg      <= div_d[FW-1:0];
                            quo_reg      <= '0;
                            cnt_reg      <= '0;
                            launched_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        rem_reg <= rem_new;
                        quo_reg <= {quo_reg[14:0], qbit};
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == 4'd15)
                        begin
                            launched_reg <= 1'b0;
                            bias_reg     <= {1'b0, quo_reg[14:0], qbit};
                            if (!div_ff_reg)
                            begin
                                prev_out_reg <= {1'b0, quo_reg[14:0], qbit};
                                state_reg    <= ST_PIN;
                            end
                            else
                            begin
                                state_reg <= ST_T1;
                            end
                        end
                    end
                end
                ST_PIN:
                begin
                    if (!launched_reg)
                    begin
                        launched_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        launched_reg <= 1'b0;
                        prev_in_reg  <= in_res;
                        acc_reg      <= '0;
                        state_reg    <= ST_DUE;
                    end
                end
                ST_DUE:
                begin
                    if (active_reg && (now_reg >= due_reg))
                    begin
                        state_reg <= ST_PV;
                    end
                    else
                    begin
                        computed_reg <= 1'b0;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_PV, ST_SP:
                begin
                    if (!launched_reg)
                    begin
                        launched_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        launched_reg <= 1'b0;
                        if (state_reg == ST_PV)
                        begin
                            pv_reg    <= in_res;
                            state_reg <= ST_SP;
                        end
                        else
                        begin
                            spf_reg   <= in_res;
                            state_reg <= ST_ERR;
                        end
                    end
                end
                ST_ERR:
                begin
                    err_reg        <= err;
                    dmeas_hold_reg <= dmeas;
                    if (!hold_int)
                    begin
                        acc_reg <= acc_sat;
                    end
                    if (ff_reg)
                    begin
                        div_ff_reg   <= 1'b1;
                        launched_reg <= 1'b0;
                        state_reg    <= ST_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_T1;
                    end
                end
                ST_T1:
                begin
                    if (!launched_reg)
                    begin
                        launched_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        launched_reg <= 1'b0;
                        t1_reg <= acc_reg[31] ? -$signed({2'b00, t1_mag})
                                              : $signed({2'b00, t1_mag});
                        state_reg <= ST_T2;
                    end
                end
                ST_T2:
                begin
                    if (!launched_reg)
                    begin
                        launched_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        launched_reg <= 1'b0;
                        t2_reg <= dmeas_hold_reg[17] ? -$signed({1'b0, t2_mag})
                                                     : $signed({1'b0, t2_mag});
                        state_reg <= ST_U;
                    end
                end
                ST_U:
                begin
                    if (!launched_reg)
                    begin
                        launched_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        launched_reg <= 1'b0;
                        o_reg        <= o_clamp;
                        state_reg    <= ST_DRV;
                    end
                end
                ST_DRV:
                begin
                    if (!launched_reg)
                    begin
                        launched_reg <= 1'b1;
                    end
                    else if (mul_done)
                    begin
                        launched_reg <= 1'b0;
                        drive_reg    <= drv_sat;
                        prev_out_reg <= o_reg;
                        prev_in_reg  <= pv_reg;
                        due_reg      <= due_new;
                        computed_reg <= 1'b1;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    // Hold until the output register is free.
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {6'd0, active_reg, computed_reg, drive_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- rtl/core/pcs_mul.sv -----
// Shift-add multiplier: one multiplier bit per cycle, shared by all products.
module pcs_mul
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pcs_pkg::MA_W-1:0]   a,
    input  logic [pcs_pkg::MB_W-1:0]   b,
    output logic                       done,
    output logic [pcs_pkg::MP_W-1:0]   prod
);

    logic [pcs_pkg::MA_W-1:0]  a_reg;
    logic [pcs_pkg::MP_W-1:0]  p_reg;
    logic [pcs_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [pcs_pkg::MA_W:0]    sum;

    // Add the multiplicand into the high half when the low bit is set.
    assign sum = {1'b0, p_reg[pcs_pkg::MP_W-1:pcs_pkg::MB_W]}
               + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pcs_pkg::CNT_W'(pcs_pkg::MB_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {{pcs_pkg::MA_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            p_reg <= {sum, p_reg[pcs_pkg::MB_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

// ----- rtl/core/pcs_chk.sv -----
// Port checker for the PID step core, bound to the top level.
`include "pid_controller_step_core_assert.svh"

module pcs_chk
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [23:0]  m_axis_tdata
);

    logic [15:0] last_drive_reg;

    // Track the drive of the last delivered word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_drive_reg <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            last_drive_reg <= m_axis_tdata[15:0];
        end
    end

    `PCS_ASSERT_NEXT(a_in_single, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "input taken twice in a row")
    `PCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
    `PCS_ASSERT_NOW(a_comp_auto, m_axis_tvalid && m_axis_tdata[16],
        m_axis_tdata[17], "computed word outside auto mode")
    `PCS_ASSERT_NOW(a_drive_held, m_axis_tvalid && m_axis_tready && !m_axis_tdata[16],
        m_axis_tdata[15:0] == last_drive_reg, "drive changed without a computation")

endmodule

bind pid_controller_step_core pcs_chk u_pcs_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/tb_pid_controller_step_core.sv -----
// Testbench of the PID step core: stream driver, stream sink and scoreboard.
`timescale 1ns / 1ps

module tb_pid_controller_step_core;

    // Scoreboard: own copy of the loop state and registers, queue of expected words.
    class pid_scoreboard;
        logic [23:0]        kc, taur, taud;
        logic signed [15:0] in_min;
        logic [31:0]        recip;
        logic [15:0]        out_min, out_span, interval;
        longint             acc, prev_in, prev_out, bias;
        logic [31:0]        next_due;
        bit                 auto_on;
        logic [15:0]        last_drive;
        logic [23:0]        expected_words[$];
        int                 errors;
        int                 results_seen;
        int                 computed_seen;

        function new();
            kc = 24'd131072; taur = 24'd13107; taud = 24'd65536;
            in_min = 16'sd0; recip = 32'd4198404;
            out_min = 16'd0; out_span = 16'd255; interval = 16'd1000;
            acc = 0; prev_in = 0; prev_out = 0; bias = 0;
            next_due = 32'd0; auto_on = 0; last_drive = 16'd0;
            errors = 0; results_seen = 0; computed_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                pcs_pkg::REG_PROP_GAIN:  kc = v[23:0];
                pcs_pkg::REG_INT_RATE:   taur = v[23:0];
                pcs_pkg::REG_DER_RATE:   taud = v[23:0];
                pcs_pkg::REG_INPUT_MIN:  in_min = v[15:0];
                pcs_pkg::REG_SPAN_RECIP: recip = v;
                pcs_pkg::REG_OUTPUT_MIN: out_min = v[15:0];
                pcs_pkg::REG_OUT_SPAN:   out_span = v[15:0];
                pcs_pkg::REG_INTERVAL:   interval = v[15:0];
                default: ;
            endcase
        endfunction

        function longint scale_input(logic [15:0] raw);
            longint d;
            longint unsigned p;
            d = longint'($signed(raw)) - longint'(in_min);
            if (d <= 0) return 0;
            p = (longint'(d) * longint'({32'd0, recip})) >> 16;
            return (p > 65536) ? 65536 : longint'(p);
        endfunction

        function longint scale_drive(logic [15:0] raw);
            longint d;
            longint unsigned span;
            longint unsigned q;
            d = longint'({48'd0, raw}) - longint'({48'd0, out_min});
            span = (out_span == 0) ? 1 : out_span;
            if (d <= 0) return 0;
            q = (longint'(d) << 16) / span;
            return (q > 65536) ? 65536 : longint'(q);
        endfunction

        // Gain product, truncated toward zero, saturating at 2^62.
        function longint gain_mul(longint a, logic [23:0] g);
            bit                neg;
            longint unsigned   mag, hi, lo, lim, r;
            neg = a < 0;
            mag = neg ? -a : a;
            hi = (mag >> 24) * g;
            lo = (mag & 64'hFFFFFF) * g;
            lim = 64'd1 << 62;
            if (hi > (lim >> 8))
                r = lim;
            else
            begin
                r = (hi << 8) + (lo >> 16);
                if (r > lim) r = lim;
            end
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // Advance the loop by one accepted input word and queue its result.
        function void note_input(logic [103:0] w);
            logic [15:0]       meas, sp, ffb, held;
            logic [31:0]       now;
            bit                want, ff, done;
            longint            pv, spf, err, dm, inner, o;
            longint unsigned   drive;
            meas = w[15:0]; sp = w[31:16]; now = w[63:32];
            want = w[64]; ff = w[65]; ffb = w[81:66]; held = w[97:82];
            done = 0;
            if (want && !auto_on)
            begin
                bias = scale_drive(ff ? ffb : held);
                prev_out = bias;
                prev_in = scale_input(meas);
                acc = 0;
            end
            auto_on = want;
            if (auto_on && now >= next_due)
            begin
                pv = scale_input(meas);
                spf = scale_input(sp);
                err = spf - pv;
                // anti-windup: hold the integral when pegged on the pushed side
                if (!(prev_out >= 65536 && err > 0) && !(prev_out <= 0 && err < 0))
                    acc = clip(acc + err, -(64'sd1 << 31), (64'sd1 << 31) - 1);
                dm = pv - prev_in;
                if (ff) bias = scale_drive(ffb);
                inner = err + gain_mul(acc, taur) - gain_mul(dm, taud);
                inner = clip(inner, -(64'sd1 << 62), 64'sd1 << 62);
                o = clip(bias + gain_mul(inner, kc), 0, 65536);
                prev_out = o;
                prev_in = pv;
                drive = longint'({48'd0, out_min}) + ((o * longint'({48'd0, out_span})) >> 16);
                last_drive = (drive > 65535) ? 16'hFFFF : drive[15:0];
                next_due = next_due + interval;
                if (next_due < now) next_due = now + interval;
                done = 1;
            end
            expected_words.push_back({6'd0, auto_on, done, last_drive});
        endfunction

        function void check_result(logic [23:0] got);
            logic [23:0] exp_w;
            results_seen++;
            if (expected_words.size() == 0)
            begin
                $error("result word 0x%06h arrived with nothing expected", got);
                errors++;
                return;
            end
            exp_w = expected_words.pop_front();
            if (exp_w[16]) computed_seen++;
            if (got[15:0] !== exp_w[15:0])
            begin
                $error("control_output: expected %0d, got %0d", exp_w[15:0], got[15:0]);
                errors++;
            end
            if (got[16] !== exp_w[16])
            begin
                $error("computed: expected %0d, got %0d", exp_w[16], got[16]);
                errors++;
            end
            if (got[17] !== exp_w[17])
            begin
                $error("in_auto: expected %0d, got %0d", exp_w[17], got[17]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    pid_scoreboard pid_sb;
    int            send_idle_pct;   // chance per cycle that the sender holds off
    int            recv_stall_pct;  // chance per cycle that the sink stalls
    logic [31:0]   stamp;           // running time stamp for well-formed samples
    int            words_sent;

    pid_controller_step_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    // Pack the input fields, measurement in the lowest bits.
    function automatic logic [103:0] pack_word(logic [15:0] meas, logic [15:0] sp,
                                               logic [31:0] now, bit auto_en, bit ff_en,
                                               logic [15:0] ffb, logic [15:0] held);
        return {6'd0, held, ffb, ff_en, auto_en, now, sp, meas};
    endfunction

    // Present one word; leave tvalid high after acceptance so back-to-back words
    // never see a low-then-high pair in the same time step.
    task automatic send_word(logic [103:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge clk); while (!s_axis_tready);
        pid_sb.note_input(w);
        words_sent++;
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        pid_sb.write_reg(idx, v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drain: drop tvalid, wait for every expected word, then let the core settle.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pid_sb.expected_words.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Load one register set: 0 defaults, 1 maxima with the most negative input minimum,
    // 2 zeros and edge values, otherwise random values in a workable range.
    task automatic load_setting(int k);
        logic [31:0] v[8];
        case (k)
            0: v = '{32'd131072, 32'd13107, 32'd65536, 32'd0, 32'd4198404,
                     32'd0, 32'd255, 32'd1000};
            1: v = '{32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'h8000, 32'hFFFFFFFF,
                     32'hFFFF, 32'hFFFF, 32'hFFFF};
            2: v = '{32'd0, 32'd0, 32'd0, 32'h7FFF, 32'd0, 32'd0, 32'd0, 32'd0};
            default:
            begin
                v[0] = $urandom_range(1 << 20);
                v[1] = ($urandom_range(3) == 0) ? $urandom_range(24'hFFFFFF)
                                                : $urandom_range(1 << 15);
                v[2] = $urandom_range(1 << 18);
                v[3] = $urandom_range(16'hFFFF);
                v[4] = ($urandom_range(3) == 0) ? $urandom
                                                : $urandom_range(1 << 24, 1 << 16);
                v[5] = $urandom_range(16'hFFFF);
                v[6] = $urandom_range(16'hFFFF);
                v[7] = $urandom_range(40);
            end
        endcase
        write_cfg(pcs_pkg::REG_PROP_GAIN, v[0]);
        write_cfg(pcs_pkg::REG_INT_RATE, v[1]);
        write_cfg(pcs_pkg::REG_DER_RATE, v[2]);
        write_cfg(pcs_pkg::REG_INPUT_MIN, v[3]);
        write_cfg(pcs_pkg::REG_SPAN_RECIP, v[4]);
        write_cfg(pcs_pkg::REG_OUTPUT_MIN, v[5]);
        write_cfg(pcs_pkg::REG_OUT_SPAN, v[6]);
        write_cfg(pcs_pkg::REG_INTERVAL, v[7]);
    endtask

    // One random sample: mostly auto with time advancing near the interval,
    // with mode drops, time jumps and raw noise mixed in.
    task automatic send_random();
        logic [15:0] meas, sp;
        bit          auto_en;
        int          pick;
        pick = $urandom_range(99);
        sp = 16'($urandom);
        meas = ($urandom_range(1) == 0) ? 16'($urandom)
                                        : 16'(sp + $urandom_range(512) - 256);
        auto_en = (pick >= 8);
        if (pick < 4)
            stamp = $urandom;
        else if (pick < 10)
            stamp = stamp - $urandom_range(50);
        else
            stamp = stamp + $urandom_range(2 * pid_sb.interval + 2);
        send_word(pack_word(meas, sp, stamp, auto_en, $urandom_range(3) == 0,
                            16'($urandom), 16'($urandom)));
    endtask

    // Sink: pick tready at the falling edge, take words at the rising edge.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                pid_sb.check_result(m_axis_tdata);
        end
    end

    initial
    begin
        int idle_mode[4][2];
        pid_sb = new();
        idle_mode = '{'{0, 0}, '{68, 0}, '{0, 68}, '{13, 13}};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        words_sent = 0;
        stamp = 32'd0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings.
        send_word(pack_word(16'd100, 16'd200, 32'd0, 0, 0, 16'd0, 16'd0));        // manual
        send_word(pack_word(16'd100, 16'd200, 32'd0, 1, 0, 16'd0, 16'd128));      // enter auto
        send_word(pack_word(16'd100, 16'd200, 32'd10, 1, 0, 16'd0, 16'd0));       // not due
        send_word(pack_word(16'h8000, 16'h7FFF, 32'd1000, 1, 0, 16'd0, 16'd0));   // extremes
        send_word(pack_word(16'h7FFF, 16'h8000, 32'd2000, 1, 1, 16'hFFFF, 16'd0));
        send_word(pack_word(16'h7FFF, 16'h7FFF, 32'd3000, 1, 1, 16'd0, 16'd0));
        send_word(pack_word(16'd0, 16'd0, 32'd3000, 0, 0, 16'd0, 16'd0));         // leave auto
        send_word(pack_word(16'd50, 16'd900, 32'd3500, 1, 1, 16'd300, 16'hFFFF)); // ff on entry
        send_word(pack_word(16'd50, 16'd900, 32'hFFFFFFFF, 1, 0, 16'd0, 16'd0));  // late, wrap
        send_word(pack_word(16'd60, 16'd900, 32'd5, 1, 0, 16'd0, 16'd0));
        send_word(pack_word(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1, 1, 16'hFFFF, 16'hFFFF));
        wait_idle();
        load_setting(1);
        send_word(pack_word(16'h8000, 16'h7FFF, 32'd0, 0, 0, 16'hFFFF, 16'hFFFF));
        send_word(pack_word(16'h8000, 16'h7FFF, 32'hFFFFFFFF, 1, 0, 16'd0, 16'hFFFF));
        send_word(pack_word(16'h7FFF, 16'h8000, 32'hFFFFFFFF, 1, 1, 16'hFFFF, 16'd0));
        send_word(pack_word(16'h1234, 16'h4321, 32'd0, 1, 0, 16'd0, 16'd0));
        wait_idle();
        load_setting(2);
        send_word(pack_word(16'h7FFF, 16'h0000, 32'd0, 1, 0, 16'd0, 16'd5));      // zero spans
        send_word(pack_word(16'h7FFF, 16'h0000, 32'd0, 1, 1, 16'd9, 16'd0));      // zero interval
        send_word(pack_word(16'h8000, 16'h7FFF, 32'd0, 1, 0, 16'd0, 16'd0));
        send_word(pack_word(16'h0001, 16'h0002, 32'd7, 0, 0, 16'd0, 16'd0));
        wait_idle();

        // Random part: eight phases, each with its own register set and one of four idling patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            load_setting((ph < 3) ? ph : 3);
            send_idle_pct  = idle_mode[ph % 4][0];
            recv_stall_pct = idle_mode[ph % 4][1];
            stamp = $urandom_range(1000);
            for (int n = 0; n < 237; n++)
                send_random();
            wait_idle();
        end

        $display("sent %0d input words over 8 register sets and 4 idling patterns;",
                 words_sent);
        $display("checked %0d result words, %0d with a new output computed",
                 pid_sb.results_seen, pid_sb.computed_seen);
        if (pid_sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pcs_pkg.sv
rtl/core/pcs_mul.sv
rtl/core/pid_controller_step_core.sv
rtl/core/pcs_chk.sv
bench/tb_pid_controller_step_core.sv
